// ===== rtl/load_cell_least_squares_calibrator_core_macros.svh =====
// Assertion macros for the load cell calibrator checker
`ifndef LOAD_CELL_LEAST_SQUARES_CALIBRATOR_CORE_MACROS_SVH
`define LOAD_CELL_LEAST_SQUARES_CALIBRATOR_CORE_MACROS_SVH

// Property checked on every clock edge outside reset
`define LCSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal holds in the cycle after a condition
`define LCSC_HOLD(lbl, cond, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) else $error(msg);

`endif

// ===== rtl/lcsc_pkg.sv =====
// Shared constants, codes and controller/datapath types for the calibrator
package lcsc_pkg;

    localparam int MAX_POINTS_DEF = 10;

    localparam int RAW_W   = 24;
    localparam int MASS_W  = 27;
    localparam int GRAV_W  = 14;
    localparam int PTF_W   = 30;
    localparam int OUT_W   = 48;
    localparam int CAL_W   = 64;
    localparam int WIDE_W  = 128;
    localparam int SX_W    = 28;
    localparam int SY_W    = 35;
    localparam int SXX_W   = 52;
    localparam int SXY_W   = 59;

    localparam logic [GRAV_W-1:0] GRAVITY_RST = 14'd9810;

    localparam logic [2:0] ACT_CONVERT = 3'd0;
    localparam logic [2:0] ACT_TARE    = 3'd1;
    localparam logic [2:0] ACT_ADD     = 3'd2;
    localparam logic [2:0] ACT_FIT     = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_BADMASS = 3'd2;
    localparam logic [2:0] STS_NOPTS   = 3'd3;
    localparam logic [2:0] STS_FITFAIL = 3'd4;
    localparam logic [2:0] STS_NCAL    = 3'd5;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_STS,
        OP_TARE,
        OP_CLEAR,
        OP_PF_DIV,
        OP_PF_STORE,
        OP_SUM_INIT,
        OP_SUM_STEP,
        OP_PROD,
        OP_DEN,
        OP_SL_DIV,
        OP_SL_DONE,
        OP_ISX_LO,
        OP_ISX_HI,
        OP_IN_DIV,
        OP_FIT_DONE,
        OP_CV_LO,
        OP_CV_HI,
        OP_CV_FORCE,
        OP_MS_DIV,
        OP_MS_DONE,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] sts;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       cal;
        logic       full;
        logic       mass_zero;
        logic       no_points;
        logic       sum_last;
        logic       denom_bad;
        logic       grav_zero;
        logic       div_done;
        logic       out_free;
    } dp_stat_t;

endpackage

// ===== rtl/load_cell_least_squares_calibrator_core.sv =====
// Load cell calibrator top level: controller, datapath and result register.
// One word in flight at a time; convert and fit use the shift-subtract divider.
// rst_n clears point count, calibration, slope, intercept and zero reading and sets
// gravity to 9810; the point store itself is not cleared.
module load_cell_least_squares_calibrator_core
#(
    parameter int MAX_POINTS = lcsc_pkg::MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         action,
    input  logic signed [23:0] raw_reading,
    input  logic [26:0]        mass_mg,
    input  logic               cfg_write_en,
    input  logic [13:0]        cfg_write_data,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         status,
    output logic signed [23:0] raw_echo,
    output logic signed [47:0] force_micro_newton,
    output logic signed [47:0] mass_milligram,
    output logic               is_calibrated,
    output logic [3:0]         points_stored,
    output logic signed [63:0] slope_value,
    output logic signed [63:0] intercept_value
);

    lcsc_pkg::dp_cmd_t  cmd;
    lcsc_pkg::dp_stat_t stat;
    logic               accept;

    assign accept = item_valid && !item_stall;

    lcsc_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    lcsc_dp #(.MAX_POINTS(MAX_POINTS)) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .accept             (accept),
        .action             (action),
        .raw_reading        (raw_reading),
        .mass_mg            (mass_mg),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .result_stall       (result_stall),
        .result_valid       (result_valid),
        .status             (status),
        .raw_echo           (raw_echo),
        .force_micro_newton (force_micro_newton),
        .mass_milligram     (mass_milligram),
        .is_calibrated      (is_calibrated),
        .points_stored      (points_stored),
        .slope_value        (slope_value),
        .intercept_value    (intercept_value)
    );

endmodule

// ===== rtl/lcsc_div.sv =====
// Shift-subtract unsigned divider, 128-bit dividend by 64-bit divisor, one bit per cycle
module lcsc_div
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [127:0] quot
);

    logic [127:0] work_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  den_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [64:0]  rem_sh;
    logic [64:0]  diff;
    logic         ge;

    always_comb
    begin
        rem_sh = {rem_reg, work_reg[127]};
        ge     = rem_sh >= {1'b0, den_reg};
        diff   = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 7'd1;
            if (cnt_reg == 7'd127)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[63:0] : rem_sh[63:0];
            work_reg <= {work_reg[126:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

// ===== rtl/lcsc_dp.sv =====
// Calibrator datapath: point store, sums, fit and convert arithmetic, result register
module lcsc_dp
#(
    parameter int MAX_POINTS = lcsc_pkg::MAX_POINTS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcsc_pkg::dp_cmd_t        cmd,
    output lcsc_pkg::dp_stat_t       stat,
    input  logic                     accept,
    input  logic [2:0]               action,
    input  logic signed [23:0]       raw_reading,
    input  logic [26:0]              mass_mg,
    input  logic                     cfg_write_en,
    input  logic [13:0]              cfg_write_data,
    input  logic                     result_stall,
    output logic                     result_valid,
    output logic [2:0]               status,
    output logic signed [23:0]       raw_echo,
    output logic signed [47:0]       force_micro_newton,
    output logic signed [47:0]       mass_milligram,
    output logic                     is_calibrated,
    output logic [3:0]               points_stored,
    output logic signed [63:0]       slope_value,
    output logic signed [63:0]       intercept_value
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NW = CW + 1;
    localparam int SX_W   = lcsc_pkg::SX_W;
    localparam int SY_W   = lcsc_pkg::SY_W;
    localparam int SXX_W  = lcsc_pkg::SXX_W;
    localparam int SXY_W  = lcsc_pkg::SXY_W;
    localparam logic [9:0]  PT_HALF = 10'd500;
    localparam logic [9:0]  PT_DIV  = 10'd1000;
    localparam logic [29:0] PT_MAX  = '1;
    localparam logic [27:0] PF_RECIP_A = 28'd137438954;
    localparam logic [24:0] PF_RECIP_B = 25'd17179870;

    logic [13:0]               grav_reg;
    logic [2:0]                act_reg;
    logic signed [23:0]        raw_reg;
    logic [26:0]               mass_reg;
    logic signed [23:0]        zero_reg;
    logic signed [23:0]        pt_rd_mem [MAX_POINTS];
    logic [29:0]               pt_f_mem  [MAX_POINTS];
    logic [CW-1:0]             cnt_reg;
    logic [IW-1:0]             idx_reg;
    logic                      cal_reg;
    logic signed [63:0]        slope_reg;
    logic signed [63:0]        icpt_reg;
    logic signed [63:0]        slope_tmp_reg;
    logic signed [SX_W-1:0]    sx_reg;
    logic signed [SY_W-1:0]    sy_reg;
    logic signed [SXX_W-1:0]   sxx_reg;
    logic signed [SXY_W-1:0]   sxy_reg;
    logic signed [63:0]        pa_reg;
    logic signed [63:0]        pb_reg;
    logic signed [63:0]        pc_reg;
    logic signed [63:0]        pd_reg;
    logic signed [63:0]        denom_reg;
    logic signed [63:0]        num_reg;
    logic signed [127:0]       wide_reg;
    logic                      neg_reg;
    logic [2:0]                sts_reg;
    logic signed [47:0]        force_reg;
    logic signed [47:0]        mass_out_reg;
    logic [3:0]                pf_stage_reg;
    logic [17:0]               pf_qm_reg;
    logic [9:0]                pf_rm_reg;
    logic [31:0]               pf_qg_reg;
    logic [23:0]               pf_b_reg;
    logic [31:0]               pf_f_reg;

    logic                      result_valid_reg;
    logic [2:0]                status_reg;
    logic signed [23:0]        raw_echo_reg;
    logic signed [47:0]        force_out_reg;
    logic signed [47:0]        mass_res_reg;
    logic                      cal_out_reg;
    logic [3:0]                points_out_reg;
    logic signed [63:0]        slope_out_reg;
    logic signed [63:0]        icpt_out_reg;

    logic [NW-1:0]             n_val;
    logic signed [NW:0]        n_s;
    logic signed [23:0]        x_cur;
    logic [29:0]               y_cur;
    logic signed [47:0]        xx_p;
    logic signed [54:0]        xy_p;
    logic signed [NW+SXX_W:0]  pa_w;
    logic signed [2*SX_W-1:0]  pb_w;
    logic signed [NW+SXY_W:0]  pc_w;
    logic signed [SX_W+SY_W-1:0] pd_w;
    logic                      cv_sel;
    logic signed [63:0]        ma;
    logic signed [SX_W-1:0]    mb;
    logic signed [32:0]        lo_s;
    logic signed [SX_W+32:0]   lo_p;
    logic signed [SX_W+31:0]   hi_p;
    logic [63:0]               num_mag;
    logic [127:0]              wide_mag;
    logic [127:0]              fq;
    logic [54:0]               pf_qa_p;
    logic [27:0]               pf_qk_p;
    logic [27:0]               pf_rem_w;
    logic [31:0]               pf_qg_p;
    logic [23:0]               pf_rg_p;
    logic [48:0]               pf_bq_p;
    logic                      pf_done;
    logic                      div_start;
    logic [127:0]              div_num;
    logic [63:0]               div_den;
    logic                      div_done;
    logic [127:0]              div_q;
    logic                      out_free;
    logic                      capture;

    function automatic logic signed [63:0] sat64(input logic [127:0] q, input logic neg);
        logic signed [63:0] r;
        if (q[127:63] != '0)
            r = neg ? $signed(64'h8000_0000_0000_0000) : $signed(64'h7FFF_FFFF_FFFF_FFFF);
        else
            r = neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic [127:0] q, input logic neg);
        logic signed [47:0] r;
        if (q[127:47] != '0)
            r = neg ? $signed(48'h8000_0000_0000) : $signed(48'h7FFF_FFFF_FFFF);
        else
            r = neg ? -$signed(q[47:0]) : $signed(q[47:0]);
        return r;
    endfunction

    assign n_val  = {1'b0, cnt_reg} + NW'(1);
    assign n_s    = $signed({1'b0, n_val});
    assign x_cur  = pt_rd_mem[idx_reg];
    assign y_cur  = pt_f_mem[idx_reg];
    assign xx_p   = x_cur * x_cur;
    assign xy_p   = x_cur * $signed({1'b0, y_cur});
    assign pa_w   = n_s * sxx_reg;
    assign pb_w   = sx_reg * sx_reg;
    assign pc_w   = n_s * sxy_reg;
    assign pd_w   = sx_reg * sy_reg;

    assign cv_sel = (cmd.op == lcsc_pkg::OP_CV_LO) || (cmd.op == lcsc_pkg::OP_CV_HI);
    assign ma     = cv_sel ? slope_reg : slope_tmp_reg;
    assign mb     = cv_sel ? SX_W'(raw_reg) : sx_reg;
    assign lo_s   = $signed({1'b0, ma[31:0]});
    assign lo_p   = lo_s * mb;
    assign hi_p   = $signed(ma[63:32]) * mb;

    assign num_mag  = num_reg[63] ? 64'(-num_reg) : num_reg;
    assign wide_mag = wide_reg[127] ? 128'(-wide_reg) : wide_reg;
    assign fq       = (wide_mag + 128'h8000_0000) >> 32;

    // point force: split mass into thousands and remainder via reciprocal multiplies
    assign pf_qa_p  = mass_reg * PF_RECIP_A;
    assign pf_qk_p  = pf_qm_reg * PT_DIV;
    assign pf_rem_w = {1'b0, mass_reg} - pf_qk_p;
    assign pf_qg_p  = pf_qm_reg * grav_reg;
    assign pf_rg_p  = pf_rm_reg * grav_reg;
    assign pf_bq_p  = pf_b_reg * PF_RECIP_B;
    assign pf_done  = pf_stage_reg[3];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            lcsc_pkg::OP_SL_DIV:
            begin
                div_start = 1'b1;
                div_num   = (128'(num_mag) << 32) + 128'(denom_reg[63:1]);
                div_den   = denom_reg;
            end
            lcsc_pkg::OP_IN_DIV:
            begin
                div_start = 1'b1;
                div_num   = wide_mag + 128'(n_val[NW-1:1]);
                div_den   = 64'(n_val);
            end
            lcsc_pkg::OP_MS_DIV:
            begin
                div_start = 1'b1;
                div_num   = (wide_mag << 10) - (wide_mag << 4) - (wide_mag << 3)
                            + (128'(grav_reg) << 31);
                div_den   = {18'b0, grav_reg, 32'b0};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    lcsc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    assign out_free = !result_valid_reg || !result_stall;
    assign capture  = (cmd.op == lcsc_pkg::OP_RESULT) && out_free;

    always_comb
    begin
        stat.action    = act_reg;
        stat.cal       = cal_reg;
        stat.full      = cnt_reg == CW'(MAX_POINTS);
        stat.mass_zero = mass_reg == '0;
        stat.no_points = cnt_reg == '0;
        stat.sum_last  = (CW'(idx_reg) + CW'(1)) == cnt_reg;
        stat.denom_bad = denom_reg[63] || (denom_reg == '0);
        stat.grav_zero = grav_reg == '0;
        stat.div_done  = div_done || pf_done;
        stat.out_free  = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_stage_reg <= '0;
        end
        else
        begin
            pf_stage_reg <= {pf_stage_reg[2:0], cmd.op == lcsc_pkg::OP_PF_DIV};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == lcsc_pkg::OP_PF_DIV)
            pf_qm_reg <= pf_qa_p[54:37];
        if (pf_stage_reg[0])
        begin
            pf_rm_reg <= pf_rem_w[9:0];
            pf_qg_reg <= pf_qg_p;
        end
        if (pf_stage_reg[1])
            pf_b_reg <= pf_rg_p + 24'(PT_HALF);
        if (pf_stage_reg[2])
            pf_f_reg <= pf_qg_reg + 32'(pf_bq_p[48:34]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg         <= lcsc_pkg::GRAVITY_RST;
            zero_reg         <= '0;
            cnt_reg          <= '0;
            cal_reg          <= 1'b0;
            slope_reg        <= '0;
            icpt_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                grav_reg <= cfg_write_data;
            case (cmd.op)
                lcsc_pkg::OP_TARE:
                    zero_reg <= raw_reg;
                lcsc_pkg::OP_CLEAR:
                begin
                    cnt_reg   <= '0;
                    cal_reg   <= 1'b0;
                    slope_reg <= '0;
                    icpt_reg  <= '0;
                end
                lcsc_pkg::OP_PF_STORE:
                    cnt_reg <= cnt_reg + CW'(1);
                lcsc_pkg::OP_FIT_DONE:
                begin
                    slope_reg <= slope_tmp_reg;
                    icpt_reg  <= sat64(div_q, neg_reg);
                    cal_reg   <= 1'b1;
                end
                default:
                begin
                    cal_reg <= cal_reg;
                end
            endcase
            if (capture)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg      <= action;
            raw_reg      <= raw_reading;
            mass_reg     <= mass_mg;
            sts_reg      <= lcsc_pkg::STS_OK;
            force_reg    <= '0;
            mass_out_reg <= '0;
        end
        case (cmd.op)
            lcsc_pkg::OP_STS:
                sts_reg <= cmd.sts;
            lcsc_pkg::OP_PF_STORE:
            begin
                pt_rd_mem[cnt_reg[IW-1:0]] <= raw_reg;
                pt_f_mem[cnt_reg[IW-1:0]]  <= (pf_f_reg > 32'(PT_MAX)) ? PT_MAX : pf_f_reg[29:0];
            end
            lcsc_pkg::OP_SUM_INIT:
            begin
                idx_reg <= '0;
                sx_reg  <= SX_W'(zero_reg);
                sy_reg  <= '0;
                sxx_reg <= SXX_W'(zero_reg * zero_reg);
                sxy_reg <= '0;
            end
            lcsc_pkg::OP_SUM_STEP:
            begin
                idx_reg <= idx_reg + IW'(1);
                sx_reg  <= sx_reg + SX_W'(x_cur);
                sy_reg  <= sy_reg + $signed(SY_W'(y_cur));
                sxx_reg <= sxx_reg + SXX_W'(xx_p);
                sxy_reg <= sxy_reg + SXY_W'(xy_p);
            end
            lcsc_pkg::OP_PROD:
            begin
                pa_reg <= 64'(pa_w);
                pb_reg <= 64'(pb_w);
                pc_reg <= 64'(pc_w);
                pd_reg <= 64'(pd_w);
            end
            lcsc_pkg::OP_DEN:
            begin
                denom_reg <= pa_reg - pb_reg;
                num_reg   <= pc_reg - pd_reg;
            end
            lcsc_pkg::OP_SL_DIV:
                neg_reg <= num_reg[63];
            lcsc_pkg::OP_SL_DONE:
                slope_tmp_reg <= sat64(div_q, neg_reg);
            lcsc_pkg::OP_ISX_LO, lcsc_pkg::OP_CV_LO:
                wide_reg <= 128'(lo_p);
            lcsc_pkg::OP_ISX_HI:
                wide_reg <= (128'(sy_reg) <<< 32) - wide_reg - (128'(hi_p) <<< 32);
            lcsc_pkg::OP_IN_DIV:
                neg_reg <= wide_reg[127];
            lcsc_pkg::OP_CV_HI:
                wide_reg <= wide_reg + (128'(hi_p) <<< 32) + 128'(icpt_reg);
            lcsc_pkg::OP_CV_FORCE:
            begin
                force_reg <= sat48(fq, wide_reg[127]);
                neg_reg   <= wide_reg[127];
            end
            lcsc_pkg::OP_MS_DONE:
                mass_out_reg <= sat48(div_q, neg_reg);
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
        if (capture)
        begin
            status_reg     <= sts_reg;
            raw_echo_reg   <= raw_reg;
            force_out_reg  <= force_reg;
            mass_res_reg   <= mass_out_reg;
            cal_out_reg    <= cal_reg;
            points_out_reg <= 4'(cnt_reg);
            slope_out_reg  <= slope_reg;
            icpt_out_reg   <= icpt_reg;
        end
    end

    assign result_valid       = result_valid_reg;
    assign status             = status_reg;
    assign raw_echo           = raw_echo_reg;
    assign force_micro_newton = force_out_reg;
    assign mass_milligram     = mass_res_reg;
    assign is_calibrated      = cal_out_reg;
    assign points_stored      = points_out_reg;
    assign slope_value        = slope_out_reg;
    assign intercept_value    = icpt_out_reg;

endmodule

// ===== rtl/lcsc_ctrl.sv =====
// Calibrator controller: decodes the action and sequences the datapath
module lcsc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lcsc_pkg::dp_stat_t  stat,
    output lcsc_pkg::dp_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_STS,
        S_TARE,
        S_CLEAR,
        S_PF_DIV,
        S_PF_WAIT,
        S_PF_STORE,
        S_SUM_INIT,
        S_SUM_STEP,
        S_PROD,
        S_DEN,
        S_CHK,
        S_SL_DIV,
        S_SL_WAIT,
        S_SL_DONE,
        S_ISX_LO,
        S_ISX_HI,
        S_IN_DIV,
        S_IN_WAIT,
        S_FIT_DONE,
        S_CV_LO,
        S_CV_HI,
        S_CV_FORCE,
        S_MS_DIV,
        S_MS_WAIT,
        S_MS_DONE,
        S_RESULT
    } state_t;

    state_t     state_reg;
    logic [2:0] sts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sts_reg   <= lcsc_pkg::STS_OK;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (item_valid)
                        state_reg <= S_DECODE;
                S_DECODE:
                    case (stat.action)
                        lcsc_pkg::ACT_CONVERT:
                            if (stat.cal)
                                state_reg <= S_CV_LO;
                            else
                            begin
                                sts_reg   <= lcsc_pkg::STS_NCAL;
                                state_reg <= S_STS;
                            end
                        lcsc_pkg::ACT_TARE:
                            state_reg <= S_TARE;
                        lcsc_pkg::ACT_ADD:
                            if (stat.mass_zero)
                            begin
                                sts_reg   <= lcsc_pkg::STS_BADMASS;
                                state_reg <= S_STS;
                            end
                            else if (stat.full)
                            begin
                                sts_reg   <= lcsc_pkg::STS_FULL;
                                state_reg <= S_STS;
                            end
                            else
                                state_reg <= S_PF_DIV;
                        lcsc_pkg::ACT_FIT:
                            if (stat.no_points)
                            begin
                                sts_reg   <= lcsc_pkg::STS_NOPTS;
                                state_reg <= S_STS;
                            end
                            else
                                state_reg <= S_SUM_INIT;
                        lcsc_pkg::ACT_CLEAR:
                            state_reg <= S_CLEAR;
                        default:
                            state_reg <= S_RESULT;
                    endcase
                S_STS, S_TARE, S_CLEAR, S_PF_STORE, S_FIT_DONE, S_MS_DONE:
                    state_reg <= S_RESULT;
                S_PF_DIV:
                    state_reg <= S_PF_WAIT;
                S_PF_WAIT:
                    if (stat.div_done)
                        state_reg <= S_PF_STORE;
                S_SUM_INIT:
                    state_reg <= S_SUM_STEP;
                S_SUM_STEP:
                    if (stat.sum_last)
                        state_reg <= S_PROD;
                S_PROD:
                    state_reg <= S_DEN;
                S_DEN:
                    state_reg <= S_CHK;
                S_CHK:
                    if (stat.denom_bad)
                    begin
                        sts_reg   <= lcsc_pkg::STS_FITFAIL;
                        state_reg <= S_STS;
                    end
                    else
                        state_reg <= S_SL_DIV;
                S_SL_DIV:
                    state_reg <= S_SL_WAIT;
                S_SL_WAIT:
                    if (stat.div_done)
                        state_reg <= S_SL_DONE;
                S_SL_DONE:
                    state_reg <= S_ISX_LO;
                S_ISX_LO:
                    state_reg <= S_ISX_HI;
                S_ISX_HI:
                    state_reg <= S_IN_DIV;
                S_IN_DIV:
                    state_reg <= S_IN_WAIT;
                S_IN_WAIT:
                    if (stat.div_done)
                        state_reg <= S_FIT_DONE;
                S_CV_LO:
                    state_reg <= S_CV_HI;
                S_CV_HI:
                    state_reg <= S_CV_FORCE;
                S_CV_FORCE:
                    state_reg <= stat.grav_zero ? S_RESULT : S_MS_DIV;
                S_MS_DIV:
                    state_reg <= S_MS_WAIT;
                S_MS_WAIT:
                    if (stat.div_done)
                        state_reg <= S_MS_DONE;
                S_RESULT:
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.sts = sts_reg;
        case (state_reg)
            S_STS:      cmd.op = lcsc_pkg::OP_STS;
            S_TARE:     cmd.op = lcsc_pkg::OP_TARE;
            S_CLEAR:    cmd.op = lcsc_pkg::OP_CLEAR;
            S_PF_DIV:   cmd.op = lcsc_pkg::OP_PF_DIV;
            S_PF_STORE: cmd.op = lcsc_pkg::OP_PF_STORE;
            S_SUM_INIT: cmd.op = lcsc_pkg::OP_SUM_INIT;
            S_SUM_STEP: cmd.op = lcsc_pkg::OP_SUM_STEP;
            S_PROD:     cmd.op = lcsc_pkg::OP_PROD;
            S_DEN:      cmd.op = lcsc_pkg::OP_DEN;
            S_SL_DIV:   cmd.op = lcsc_pkg::OP_SL_DIV;
            S_SL_DONE:  cmd.op = lcsc_pkg::OP_SL_DONE;
            S_ISX_LO:   cmd.op = lcsc_pkg::OP_ISX_LO;
            S_ISX_HI:   cmd.op = lcsc_pkg::OP_ISX_HI;
            S_IN_DIV:   cmd.op = lcsc_pkg::OP_IN_DIV;
            S_FIT_DONE: cmd.op = lcsc_pkg::OP_FIT_DONE;
            S_CV_LO:    cmd.op = lcsc_pkg::OP_CV_LO;
            S_CV_HI:    cmd.op = lcsc_pkg::OP_CV_HI;
            S_CV_FORCE: cmd.op = lcsc_pkg::OP_CV_FORCE;
            S_MS_DIV:   cmd.op = lcsc_pkg::OP_MS_DIV;
            S_MS_DONE:  cmd.op = lcsc_pkg::OP_MS_DONE;
            S_RESULT:   cmd.op = lcsc_pkg::OP_RESULT;
            default:    cmd.op = lcsc_pkg::OP_IDLE;
        endcase
    end

    assign item_stall = state_reg != S_IDLE;

endmodule

// ===== rtl/lcsc_checker.sv =====
// Port-level assertions for the calibrator, bound to the top level
`include "load_cell_least_squares_calibrator_core_macros.svh"

module lcsc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic               result_valid,
    input logic               result_stall,
    input logic [2:0]         status,
    input logic signed [47:0] force_micro_newton,
    input logic               is_calibrated,
    input logic signed [63:0] slope_value,
    input logic signed [63:0] intercept_value
);

    `LCSC_HOLD(a_item_hold, item_valid && item_stall, item_valid, "input word dropped while stalled")
    `LCSC_HOLD(a_result_hold, result_valid && result_stall, result_valid, "result word dropped while stalled")
    `LCSC_ASSERT(a_ncal_zero, result_valid && status == lcsc_pkg::STS_NCAL |-> !is_calibrated && force_micro_newton == 48'sd0, "not-calibrated word carries a force")
    `LCSC_ASSERT(a_force_ok, result_valid && force_micro_newton != 48'sd0 |-> status == lcsc_pkg::STS_OK && is_calibrated, "force without a calibrated convert")
    `LCSC_ASSERT(a_uncal_line, result_valid && !is_calibrated |-> slope_value == 64'sd0 && intercept_value == 64'sd0, "line set while uncalibrated")

endmodule

bind load_cell_least_squares_calibrator_core lcsc_checker u_lcsc_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_valid),
    .item_stall         (item_stall),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .status             (status),
    .force_micro_newton (force_micro_newton),
    .is_calibrated      (is_calibrated),
    .slope_value        (slope_value),
    .intercept_value    (intercept_value)
);
